FILE: design/ssrs_pkg.sv
// ----------------------------------------------------------------------------
// ssrs_pkg
// shared constants for the secondary structure run segmenter: register
// indexes, reset values, region kinds and default sizing
// ----------------------------------------------------------------------------
package ssrs_pkg;

  // default chain length limit
  localparam int MAX_RESIDUES_DEF = 4096;

  // default region field widths: starts stop at the limit minus one, ends reach it
  localparam int POS_W_DEF = $clog2(MAX_RESIDUES_DEF);
  localparam int END_W_DEF = $clog2(MAX_RESIDUES_DEF + 1);

  // configuration port
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HELIX_ENTER_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HELIX_CORE_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HELIX_MIN_CORE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND_MIN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND_MIN_BOND = 3'd4;

  // probability fraction width
  localparam int PROB_W = 16;

  // reset values of the registers
  localparam logic [PROB_W-1:0] HELIX_ENTER_THR_RST = 16'd32768;
  localparam logic [PROB_W-1:0] HELIX_CORE_THR_RST  = 16'd49152;
  localparam int HELIX_MIN_CORE_RST  = 4;
  localparam int STRAND_MIN_LEN_RST  = 3;
  localparam int STRAND_MIN_BOND_RST = 2;

  // region kinds
  localparam logic KIND_HELIX  = 1'b0;
  localparam logic KIND_STRAND = 1'b1;

endpackage

FILE: design/ssrs_in_if.sv
// ----------------------------------------------------------------------------
// ssrs_in_if
// residue channel: one word per residue
// ----------------------------------------------------------------------------
interface ssrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssrs_pkg::PROB_W-1:0] helix_prob;
  logic                       has_profile;
  logic                       strand_bonded;
  logic                       last_residue;

  modport src (output valid, output helix_prob, output has_profile,
               output strand_bonded, output last_residue, input ready);
  modport snk (input valid, input helix_prob, input has_profile,
               input strand_bonded, input last_residue, output ready);
endinterface

FILE: design/ssrs_out_if.sv
// ----------------------------------------------------------------------------
// ssrs_out_if
// region channel: one word per closed region
// ----------------------------------------------------------------------------
interface ssrs_out_if #(
  parameter int POS_W = ssrs_pkg::POS_W_DEF,
  parameter int END_W = ssrs_pkg::END_W_DEF
);
  logic             valid;
  logic             ready;
  logic             region_kind;
  logic [POS_W-1:0] region_start;
  logic [END_W-1:0] region_end;
  logic             last_of_item;

  modport src (output valid, output region_kind, output region_start,
               output region_end, output last_of_item, input ready);
  modport snk (input valid, input region_kind, input region_start,
               input region_end, input last_of_item, output ready);
endinterface

FILE: design/ssrs_cfg_if.sv
// ----------------------------------------------------------------------------
// ssrs_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
interface ssrs_cfg_if #(
  parameter int DATA_W = 16
);
  logic                          valid;
  logic                          ready;
  logic [ssrs_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]             data;

  modport src (output valid, output index, output data, input ready);
  modport snk (input valid, input index, input data, output ready);
endinterface

FILE: design/secondary_structure_run_segmenter.sv
// ----------------------------------------------------------------------------
// secondary_structure_run_segmenter
// tracks one helix run and one strand run over a residue stream and emits
// each region as it closes, helix before strand when both close together
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       word
//  in_bus    in   valid / ready   helix_prob, has_profile, strand_bonded,
//                                 last_residue
//  out_bus   out  valid / ready   region_kind, region_start, region_end,
//                                 last_of_item
//  cfg_bus   in   valid / ready   index, data (ready always high)
//
//  one residue is taken per cycle while in_bus.ready is high; its run state
//  is updated in the same cycle and the zero, one or two regions it closes go
//  into a four-word result queue; the queue drains one region per cycle, so
//  the output side sets the rate when many residues close two regions each
//  in_bus.ready is high while the queue has room for two words
//  rst_n is synchronous, active low: clears run state, queue and registers
//  to their reset values
//
module secondary_structure_run_segmenter #(
  parameter int MAX_RESIDUES = ssrs_pkg::MAX_RESIDUES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ssrs_in_if.snk         in_bus,
  ssrs_out_if.src        out_bus,
  ssrs_cfg_if.snk        cfg_bus
);

  // counts reach MAX_RESIDUES, positions stop at MAX_RESIDUES-1
  localparam int IDX_W = $clog2(MAX_RESIDUES + 1);
  localparam int POS_W = $clog2(MAX_RESIDUES);
  localparam int PW    = ssrs_pkg::PROB_W;
  localparam logic [IDX_W-1:0] MAX_CNT  = IDX_W'(MAX_RESIDUES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_RESIDUES - 1);

  // result queue
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] start;
    logic [IDX_W-1:0] stop;
    logic             last;
  } result_t;

  function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
    return (v < MAX_CNT) ? v + 1'b1 : MAX_CNT;
  endfunction

  // exclusive end, saturated at the chain limit
  function automatic logic [IDX_W-1:0] region_stop(input logic [POS_W-1:0] s,
                                                   input logic [IDX_W-1:0] l);
    logic [IDX_W:0] sum;
    sum = {1'b0, IDX_W'(s)} + {1'b0, l};
    return (sum > {1'b0, MAX_CNT}) ? MAX_CNT : sum[IDX_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [PW-1:0]    enter_thr_r, core_thr_r;
  logic [IDX_W-1:0] min_core_r, min_len_r, min_bond_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_thr_r <= ssrs_pkg::HELIX_ENTER_THR_RST;
      core_thr_r  <= ssrs_pkg::HELIX_CORE_THR_RST;
      min_core_r  <= IDX_W'(ssrs_pkg::HELIX_MIN_CORE_RST);
      min_len_r   <= IDX_W'(ssrs_pkg::STRAND_MIN_LEN_RST);
      min_bond_r  <= IDX_W'(ssrs_pkg::STRAND_MIN_BOND_RST);
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        ssrs_pkg::REG_HELIX_ENTER_THR: enter_thr_r <= cfg_bus.data[PW-1:0];
        ssrs_pkg::REG_HELIX_CORE_THR:  core_thr_r  <= cfg_bus.data[PW-1:0];
        ssrs_pkg::REG_HELIX_MIN_CORE:  min_core_r  <= cfg_bus.data[IDX_W-1:0];
        ssrs_pkg::REG_STRAND_MIN_LEN:  min_len_r   <= cfg_bus.data[IDX_W-1:0];
        ssrs_pkg::REG_STRAND_MIN_BOND: min_bond_r  <= cfg_bus.data[IDX_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // run state
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             h_open_r, h_open_nxt;
  logic [POS_W-1:0] h_start_r, h_start_nxt;
  logic [IDX_W-1:0] h_len_r, h_len_nxt;
  logic [IDX_W-1:0] h_core_r, h_core_nxt;
  logic             s_open_r, s_open_nxt;
  logic [POS_W-1:0] s_start_r, s_start_nxt;
  logic [IDX_W-1:0] s_len_r, s_len_nxt;
  logic [IDX_W-1:0] s_bond_r, s_bond_nxt;
  logic             prev_bond_r, prev_bond_nxt;

  // queue
  result_t         q_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] cnt_r;

  logic in_fire, out_fire;
  assign in_bus.ready = (cnt_r <= QC_W'(QDEPTH - 2));
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_fire     = out_bus.valid && out_bus.ready;

  // per residue step
  logic [POS_W-1:0] pos;
  logic             h_hit, h_close, h_emit, h_flush, h_res;
  logic             s_close, s_emit, s_flush, s_res;
  logic [IDX_W-1:0] h_len_out, s_len_out;
  logic             h_open1, s_open1;
  logic [POS_W-1:0] h_start1, s_start1;
  logic [IDX_W-1:0] h_len1, h_core1, s_len1, s_bond1;
  result_t          h_word, s_word, w0, w1;
  logic [1:0]       push_n;

  always_comb begin
    pos = (idx_r < MAX_CNT) ? idx_r[POS_W-1:0] : LAST_POS;

    // helix: residues without a profile leave the run untouched
    h_hit   = in_bus.has_profile && (in_bus.helix_prob > enter_thr_r);
    h_close = in_bus.has_profile && !h_hit;
    h_emit  = h_close && h_open_r && (h_core_r >= min_core_r);

    h_open1  = h_open_r;
    h_start1 = h_start_r;
    h_len1   = h_len_r;
    h_core1  = h_core_r;
    if (h_hit) begin
      if (!h_open_r) begin
        h_start1 = pos;
        h_len1   = '0;
        h_core1  = '0;
      end
      h_open1 = 1'b1;
      h_len1  = sat_inc(h_len1);
      if (in_bus.helix_prob > core_thr_r) h_core1 = sat_inc(h_core1);
    end else if (h_close) begin
      h_open1 = 1'b0;
      h_len1  = '0;
      h_core1 = '0;
    end

    // strand: one unbonded residue after a bonded one is bridged
    s_close = !in_bus.strand_bonded && s_open_r && !prev_bond_r;
    s_emit  = s_close && (s_len_r >= min_len_r) && (s_bond_r >= min_bond_r);

    s_open1  = s_open_r;
    s_start1 = s_start_r;
    s_len1   = s_len_r;
    s_bond1  = s_bond_r;
    if (in_bus.strand_bonded) begin
      if (!s_open_r) begin
        s_start1 = pos;
        s_len1   = '0;
        s_bond1  = '0;
      end
      s_open1 = 1'b1;
      s_len1  = sat_inc(s_len1);
      s_bond1 = sat_inc(s_bond1);
    end else if (s_open_r) begin
      if (prev_bond_r) begin
        s_len1 = sat_inc(s_len1);
      end else begin
        s_open1 = 1'b0;
        s_len1  = '0;
        s_bond1 = '0;
      end
    end

    // chain end flush, strand needs strictly more bonded residues here
    h_flush = in_bus.last_residue && h_open1 && (h_core1 >= min_core_r);
    s_flush = in_bus.last_residue && s_open1 && (s_len1 >= min_len_r)
              && (s_bond1 > min_bond_r);

    // a run closed mid-residue is no longer open, so at most one of each kind
    h_res     = h_emit || h_flush;
    s_res     = s_emit || s_flush;
    h_len_out = h_emit ? h_len_r : h_len1;
    s_len_out = s_emit ? s_len_r : s_len1;

    h_word.kind  = ssrs_pkg::KIND_HELIX;
    h_word.start = h_start1;
    h_word.stop  = region_stop(h_start1, h_len_out);
    h_word.last  = !s_res;
    s_word.kind  = ssrs_pkg::KIND_STRAND;
    s_word.start = s_start1;
    s_word.stop  = region_stop(s_start1, s_len_out);
    s_word.last  = 1'b1;

    w0     = h_res ? h_word : s_word;
    w1     = s_word;
    push_n = in_fire ? ({1'b0, h_res} + {1'b0, s_res}) : 2'd0;

    // next state
    if (in_bus.last_residue) begin
      idx_nxt       = '0;
      h_open_nxt    = 1'b0;
      h_start_nxt   = '0;
      h_len_nxt     = '0;
      h_core_nxt    = '0;
      s_open_nxt    = 1'b0;
      s_start_nxt   = '0;
      s_len_nxt     = '0;
      s_bond_nxt    = '0;
      prev_bond_nxt = 1'b0;
    end else begin
      idx_nxt       = sat_inc(idx_r);
      h_open_nxt    = h_open1;
      h_start_nxt   = h_start1;
      h_len_nxt     = h_len1;
      h_core_nxt    = h_core1;
      s_open_nxt    = s_open1;
      s_start_nxt   = s_start1;
      s_len_nxt     = s_len1;
      s_bond_nxt    = s_bond1;
      prev_bond_nxt = in_bus.strand_bonded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      h_open_r    <= 1'b0;
      h_start_r   <= '0;
      h_len_r     <= '0;
      h_core_r    <= '0;
      s_open_r    <= 1'b0;
      s_start_r   <= '0;
      s_len_r     <= '0;
      s_bond_r    <= '0;
      prev_bond_r <= 1'b0;
    end else if (in_fire) begin
      idx_r       <= idx_nxt;
      h_open_r    <= h_open_nxt;
      h_start_r   <= h_start_nxt;
      h_len_r     <= h_len_nxt;
      h_core_r    <= h_core_nxt;
      s_open_r    <= s_open_nxt;
      s_start_r   <= s_start_nxt;
      s_len_r     <= s_len_nxt;
      s_bond_r    <= s_bond_nxt;
      prev_bond_r <= prev_bond_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result queue, up to two words in and one word out per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= w0;
    if (push_n == 2'd2) q_r[wr_ptr_r + 1'b1] <= w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QA_W'(push_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QC_W'(push_n) - QC_W'(out_fire);
    end
  end

  assign out_bus.valid        = (cnt_r != '0);
  assign out_bus.region_kind  = q_r[rd_ptr_r].kind;
  assign out_bus.region_start = q_r[rd_ptr_r].start;
  assign out_bus.region_end   = q_r[rd_ptr_r].stop;
  assign out_bus.last_of_item = q_r[rd_ptr_r].last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QC_W'(QDEPTH))
    else $error("result queue overfilled");

  a_queue_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[QA_W-1:0] == QA_W'(wr_ptr_r - rd_ptr_r))
    else $error("queue count and pointers disagree");

  a_one_helix: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !(h_emit && h_flush))
    else $error("helix closed and flushed on one residue");

  a_chain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.last_residue |=> idx_r == '0 && !h_open_r && !s_open_r)
    else $error("state not cleared after chain end");

endmodule

FILE: test/secondary_structure_run_segmenter_tb.sv
// ----------------------------------------------------------------------------
// secondary_structure_run_segmenter_tb
// self-checking bench for the run segmenter: residue words go in through a
// queue-fed driver, a local copy of the helix and strand run tracking works
// out the regions each residue closes, and a monitor checks every region word
// against the oldest prediction while, in most tests, both sides idle and stall at random
// ----------------------------------------------------------------------------
module secondary_structure_run_segmenter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RES      = ssrs_pkg::MAX_RESIDUES_DEF;
  // generous bound: every residue closing two regions, each waiting out the
  // longest stall, plus the longest sender gap, taken a few times over
  localparam int RUN_LIMIT    = 3_000_000;
  // settling wait at the end of a drain; the result queue is four words deep
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  // indexes past the register file, which the block must ignore
  localparam logic [ssrs_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [ssrs_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ssrs_pkg::PROB_W-1:0] helix_prob;
    logic                        has_profile;
    logic                        strand_bonded;
    logic                        last_residue;
  } residue_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] region_start;
    logic [12:0] region_end;
    logic        last_of_item;
  } region_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // channels and the block
  ssrs_in_if  in_if ();
  ssrs_out_if out_if ();
  ssrs_cfg_if cfg_if ();

  secondary_structure_run_segmenter i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // everything the bench drives has a known value from time zero
  residue_t                        cur_residue = '0;
  logic                            in_valid    = 1'b0;
  logic                            out_ready   = 1'b0;
  logic                            cfg_valid   = 1'b0;
  logic [ssrs_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [15:0]                     cfg_data    = '0;

  assign in_if.valid         = in_valid;
  assign in_if.helix_prob    = cur_residue.helix_prob;
  assign in_if.has_profile   = cur_residue.has_profile;
  assign in_if.strand_bonded = cur_residue.strand_bonded;
  assign in_if.last_residue  = cur_residue.last_residue;
  assign out_if.ready        = out_ready;
  assign cfg_if.valid        = cfg_valid;
  assign cfg_if.index        = cfg_index;
  assign cfg_if.data         = cfg_data;

  // queues between stimulus, driver and monitor
  residue_t pending_q[$];
  region_t  region_q[$];

  int  errors      = 0;
  int  cycle_count = 0;
  bit  pace_gaps   = 1'b1;   // random idling on both sides when set
  int  hold_asks   = 0;      // bumped by the stimulus to ask for a long hold-off
  bit  in_holding  = 1'b0;   // a residue word sits on the input bus

  // local copy of the registers
  logic [ssrs_pkg::PROB_W-1:0] enter_thr;
  logic [ssrs_pkg::PROB_W-1:0] core_thr;
  logic [12:0]                 min_core;
  logic [12:0]                 min_len;
  logic [12:0]                 min_bond;

  // local copy of the run state
  logic [12:0] seg_index;
  logic        hx_open;
  logic [11:0] hx_start;
  logic [12:0] hx_len;
  logic [12:0] hx_core;
  logic        st_open;
  logic [11:0] st_start;
  logic [12:0] st_len;
  logic [12:0] st_bonded;
  logic        prev_bonded;

  // append a residue word to the driver's queue
  task automatic put_residue(input residue_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // run tracking
  // ---------------------------------------------------------------------------

  // counters stick at the chain length limit
  function automatic logic [12:0] sat_inc(input logic [12:0] v);
    return (v < MAX_RES) ? v + 13'd1 : 13'(MAX_RES);
  endfunction

  // exclusive end, held at the chain length limit
  function automatic region_t make_region(input logic kind, input logic [11:0] start,
                                          input logic [12:0] len);
    region_t     r;
    logic [13:0] stop;
    stop = {2'b00, start} + {1'b0, len};
    if (stop > MAX_RES) stop = 14'(MAX_RES);
    r.kind         = kind;
    r.region_start = start;
    r.region_end   = stop[12:0];
    r.last_of_item = 1'b0;
    return r;
  endfunction

  task automatic clear_runs();
    seg_index   = '0;
    hx_open     = 1'b0;
    hx_start    = '0;
    hx_len      = '0;
    hx_core     = '0;
    st_open     = 1'b0;
    st_start    = '0;
    st_len      = '0;
    st_bonded   = '0;
    prev_bonded = 1'b0;
  endtask

  // one accepted residue: update both runs and queue the regions it closes
  task automatic track_residue(input residue_t r);
    region_t     closed[$];
    logic [11:0] pos;
    pos = (seg_index < MAX_RES) ? seg_index[11:0] : 12'(MAX_RES - 1);

    // helix: residues without a profile are passed over entirely
    if (r.has_profile) begin
      if (r.helix_prob > enter_thr) begin
        if (!hx_open) begin
          hx_open  = 1'b1;
          hx_start = pos;
          hx_len   = '0;
          hx_core  = '0;
        end
        hx_len = sat_inc(hx_len);
        if (r.helix_prob > core_thr) hx_core = sat_inc(hx_core);
      end else begin
        if (hx_open && hx_core >= min_core)
          closed.insert(closed.size(),
                        make_region(ssrs_pkg::KIND_HELIX, hx_start, hx_len));
        hx_open = 1'b0;
        hx_len  = '0;
        hx_core = '0;
      end
    end

    // strand: one unbonded residue after a bonded one is bridged and counted
    if (r.strand_bonded) begin
      if (!st_open) begin
        st_open   = 1'b1;
        st_start  = pos;
        st_len    = '0;
        st_bonded = '0;
      end
      st_len    = sat_inc(st_len);
      st_bonded = sat_inc(st_bonded);
    end else if (st_open) begin
      if (prev_bonded) begin
        st_len = sat_inc(st_len);
      end else begin
        if (st_len >= min_len && st_bonded >= min_bond)
          closed.insert(closed.size(),
                        make_region(ssrs_pkg::KIND_STRAND, st_start, st_len));
        st_open   = 1'b0;
        st_len    = '0;
        st_bonded = '0;
      end
    end
    prev_bonded = r.strand_bonded;

    // chain end: flush both runs, the strand test is strict here
    if (r.last_residue) begin
      if (hx_open && hx_core >= min_core)
        closed.insert(closed.size(),
                      make_region(ssrs_pkg::KIND_HELIX, hx_start, hx_len));
      if (st_open && st_len >= min_len && st_bonded > min_bond)
        closed.insert(closed.size(),
                      make_region(ssrs_pkg::KIND_STRAND, st_start, st_len));
      clear_runs();
    end else begin
      seg_index = sat_inc(seg_index);
    end

    foreach (closed[i]) begin
      closed[i].last_of_item = (i == closed.size() - 1);
      region_q.insert(region_q.size(), closed[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // residue driver: words change on the falling edge, taken on the rising edge
  // ---------------------------------------------------------------------------

  // most gaps short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  int in_idle_left = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_if.ready) begin
      track_residue(cur_residue);
      in_holding = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !in_holding) begin
      if (in_idle_left > 0) begin
        in_idle_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 && pace_gaps && $urandom_range(0, 99) < 30) begin
        in_idle_left = gap_len() - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_residue = pending_q.pop_front();
        in_holding  = 1'b1;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // region monitor: ready paced on the falling edge, words checked on the rising
  // ---------------------------------------------------------------------------
  int      hold_seen  = 0;
  int      hold_left  = 0;
  int      stall_left = 0;
  region_t seen_region;
  region_t want_region;

  always @(negedge clk) begin
    if (rst_n) begin
      // a long hold-off lets the result queue fill and back up the input
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (pace_gaps && $urandom_range(0, 99) < 25) begin
        stall_left = gap_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_ready) begin
      seen_region = {out_if.region_kind, out_if.region_start, out_if.region_end,
                     out_if.last_of_item};
      if (region_q.size() == 0) begin
        $display("%0t ns: region word with nothing expected: kind %0d start %0d end %0d last %0d",
                 $time, seen_region.kind, seen_region.region_start,
                 seen_region.region_end, seen_region.last_of_item);
        errors++;
      end else begin
        want_region = region_q.pop_front();
        if (seen_region !== want_region) begin
          $display("%0t ns: region mismatch: expected kind %0d start %0d end %0d last %0d",
                   $time, want_region.kind, want_region.region_start,
                   want_region.region_end, want_region.last_of_item);
          $display("%0t ns:                  actual   kind %0d start %0d end %0d last %0d",
                   $time, seen_region.kind, seen_region.region_start,
                   seen_region.region_end, seen_region.last_of_item);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t ns: timed out with %0d regions outstanding", $time, region_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic residue_t mk_residue(input logic [15:0] prob, input logic prof,
                                          input logic bond, input logic last);
    residue_t r;
    r.helix_prob    = prob;
    r.has_profile   = prof;
    r.strand_bonded = bond;
    r.last_residue  = last;
    return r;
  endfunction

  // a probability that extends a helix, leaning on the threshold boundaries
  function automatic logic [15:0] prob_above_enter();
    int lo;
    int pick;
    if (enter_thr == 16'hFFFF) return 16'($urandom);
    lo = int'(enter_thr) + 1;
    case ($urandom_range(0, 5))
      0: pick = lo;
      1: pick = 65535;
      2: pick = int'(core_thr) + 1;
      3: pick = int'(core_thr);
      default: pick = int'($urandom_range(lo, 65535));
    endcase
    if (pick < lo || pick > 65535) pick = int'($urandom_range(lo, 65535));
    return 16'(pick);
  endfunction

  function automatic logic [15:0] prob_at_or_below_enter();
    case ($urandom_range(0, 3))
      0: return enter_thr;
      1: return 16'd0;
      default: return 16'($urandom_range(0, int'(enter_thr)));
    endcase
  endfunction

  // chains mostly of modest length, some very short, a few long
  function automatic int chain_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 40);
    return $urandom_range(60, 120);
  endfunction

  // well-formed helix and strand runs with random content, plus some noise
  task automatic queue_random(input int count);
    residue_t r;
    int       chain_left;
    int       pick;
    bit       in_helix;
    bit       strand_on;
    chain_left = chain_length();
    in_helix   = 1'b0;
    strand_on  = 1'b0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        r.helix_prob    = 16'($urandom);
        r.has_profile   = 1'($urandom_range(0, 1));
        r.strand_bonded = 1'($urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 99) < 15) in_helix = !in_helix;
        r.has_profile = ($urandom_range(0, 99) < 90);
        r.helix_prob  = in_helix ? prob_above_enter() : prob_at_or_below_enter();
        if (strand_on) begin
          // mostly bonded, sometimes a bridged gap, sometimes the run ends
          pick            = $urandom_range(0, 99);
          r.strand_bonded = (pick < 70);
          if (pick >= 90) strand_on = 1'b0;
        end else begin
          strand_on       = ($urandom_range(0, 99) < 20);
          r.strand_bonded = strand_on;
        end
      end
      chain_left--;
      r.last_residue = (chain_left == 0);
      if (chain_left == 0) chain_left = chain_length();
      put_residue(r);
    end
  endtask

  // wait until every word is in and every region is out, then let it settle
  task automatic drain();
    while (pending_q.size() != 0 || in_holding || region_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ssrs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      ssrs_pkg::REG_HELIX_ENTER_THR: enter_thr = data;
      ssrs_pkg::REG_HELIX_CORE_THR:  core_thr  = data;
      ssrs_pkg::REG_HELIX_MIN_CORE:  min_core  = data[12:0];
      ssrs_pkg::REG_STRAND_MIN_LEN:  min_len   = data[12:0];
      ssrs_pkg::REG_STRAND_MIN_BOND: min_bond  = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] enter, input logic [15:0] core,
                            input logic [15:0] mcore, input logic [15:0] mlen,
                            input logic [15:0] mbond);
    write_reg(ssrs_pkg::REG_HELIX_ENTER_THR, enter);
    write_reg(ssrs_pkg::REG_HELIX_CORE_THR, core);
    write_reg(ssrs_pkg::REG_HELIX_MIN_CORE, mcore);
    write_reg(ssrs_pkg::REG_STRAND_MIN_LEN, mlen);
    write_reg(ssrs_pkg::REG_STRAND_MIN_BOND, mbond);
  endtask

  initial begin
    enter_thr = ssrs_pkg::HELIX_ENTER_THR_RST;
    core_thr  = ssrs_pkg::HELIX_CORE_THR_RST;
    min_core  = 13'(ssrs_pkg::HELIX_MIN_CORE_RST);
    min_len   = 13'(ssrs_pkg::STRAND_MIN_LEN_RST);
    min_bond  = 13'(ssrs_pkg::STRAND_MIN_BOND_RST);
    clear_runs();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed chain at reset settings
    // helix with a skipped residue, the core boundary hit exactly, and a
    // strand bridging two gaps that closes first
    put_residue(mk_residue(16'hFFFF, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'hC001, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'h0000, 1'b0, 1'b0, 1'b0));
    put_residue(mk_residue(16'hC000, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'hC001, 1'b1, 1'b0, 1'b0));
    put_residue(mk_residue(16'hFFFF, 1'b1, 1'b0, 1'b0));
    // exactly at the enter threshold closes the helix
    put_residue(mk_residue(16'h8000, 1'b1, 1'b0, 1'b0));
    // helix and strand closing on the same word, helix first
    for (int i = 0; i < 4; i++)
      put_residue(mk_residue(16'hFFFF, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'hFFFF, 1'b1, 1'b0, 1'b0));
    put_residue(mk_residue(16'h0000, 1'b1, 1'b0, 1'b0));
    // shortest strand that passes mid-chain
    put_residue(mk_residue(16'h1234, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'h8000, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'h0001, 1'b1, 1'b0, 1'b0));
    put_residue(mk_residue(16'h7FFF, 1'b1, 1'b0, 1'b0));
    // strand with only two bonded at chain end is dropped
    put_residue(mk_residue(16'h0000, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'h0000, 1'b1, 1'b1, 1'b1));
    // new chain: both runs flushed by the last residue
    for (int i = 0; i < 3; i++)
      put_residue(mk_residue(16'hFFFF, 1'b1, 1'b1, 1'b0));
    put_residue(mk_residue(16'hFFFF, 1'b1, 1'b1, 1'b1));
    // a lone last residue on an empty chain
    put_residue(mk_residue(16'hFFFF, 1'b0, 1'b0, 1'b1));
    drain();

    // random at reset settings
    queue_random(250);
    drain();

    // all zero: every valid residue above zero opens a helix, every run passes;
    // the receiver holds off while the sender keeps offering
    set_config(16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0);
    @(posedge clk);
    hold_asks++;
    queue_random(250);
    drain();

    // top of every range, no idling on either side
    pace_gaps = 1'b0;
    set_config(16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096, 16'd4096);
    queue_random(150);
    drain();

    // minimums written with bits above their width, and stray indexes
    pace_gaps = 1'b1;
    set_config(16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNUSED_LO, 16'($urandom));
    write_reg(REG_UNUSED_HI, 16'($urandom));
    queue_random(100);
    drain();

    // random settings with small minimums, one stretch without idling
    for (int p = 0; p < 4; p++) begin
      pace_gaps = (p != 2);
      set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 6)),
                 16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
      queue_random(250);
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ssrs_pkg.sv
design/ssrs_in_if.sv
design/ssrs_out_if.sv
design/ssrs_cfg_if.sv
design/secondary_structure_run_segmenter.sv
test/secondary_structure_run_segmenter_tb.sv
